/* hdl/dtt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dtt_pkg;

    // Command codes on the input channel
    localparam logic [2:0] CMD_ADD     = 3'd0;
    localparam logic [2:0] CMD_CANCEL  = 3'd1;
    localparam logic [2:0] CMD_REFRESH = 3'd2;
    localparam logic [2:0] CMD_RESET   = 3'd3;
    localparam logic [2:0] CMD_EXPIRE  = 3'd4;
    localparam logic [2:0] CMD_NEXT    = 3'd5;

    // Result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // Backward clock step that expires everything
    localparam logic [63:0] HOUR_MS = 64'd3600000;
    localparam logic [63:0] ALL_ONES = '1;

    // Most timers fired by one expire
    localparam int MAX_RESULTS = 16;

endpackage

`default_nettype wire

/* hdl/deadline_timer_table_top.sv */
// Deadline timer table: NUM_TIMERS numbered one-shot or recurring millisecond
// timers with add, cancel, refresh, reset, expire and next-deadline commands.
// One command is worked at a time; s_ready is high only when the sequencer is
// idle. Deadlines sit in a RAM with one read and one write port that a shared
// 64-bit compare unit walks one slot per cycle. Add and next walk the table, as
// does a reset that moves the deadline; cancel and refresh do not. Expire scans
// once to find due timers and then once more per fired timer, at most 16 per
// command. Each result beat waits in an output register.
`timescale 1ns / 1ps
`default_nettype none

module deadline_timer_table_top #(
    parameter int NUM_TIMERS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_cmd,
    input  wire logic [3:0]  s_timer_id,
    input  wire logic [31:0] s_interval_ms,
    input  wire logic        s_recurring,
    input  wire logic        s_restart_now,
    input  wire logic [63:0] s_now_ms,
    input  wire logic        s_query_next,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_status,
    output logic             m_fired,
    output logic [3:0]       m_fired_id,
    output logic [63:0]      m_time_left,
    output logic             m_front_notice,
    output logic             m_clock_jumped,
    output logic             m_any_armed,
    output logic             m_last
);

    localparam int IW = $clog2(NUM_TIMERS);
    localparam int CW = IW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_SLOT, S_RST2, S_SCAN, S_AFTER, S_FIRE, S_FIRE2, S_EMIT
    } state_t;

    typedef enum logic [1:0] {SM_EARLY, SM_DUE, SM_PICK} scan_mode_t;

    state_t state_reg, state_next;
    scan_mode_t mode_reg, mode_next;

    logic [2:0]  cmd_reg, cmd_next;
    logic [3:0]  id_reg, id_next;
    logic [31:0] ivl_reg, ivl_next;
    logic        rec_reg, rec_next;
    logic        fnow_reg, fnow_next;
    logic [63:0] now_reg, now_next;
    logic        query_reg, query_next;

    logic [NUM_TIMERS-1:0] armed_reg, armed_next;
    logic [NUM_TIMERS-1:0] rep_reg, rep_next;
    logic [NUM_TIMERS-1:0] due_reg, due_next;
    logic        notice_reg, notice_next;
    logic [63:0] prev_reg, prev_next;

    logic [CW-1:0] scan_cnt_reg, scan_cnt_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          best_vld_reg, best_vld_next;
    logic [63:0]   best_dl_reg, best_dl_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    logic [CW-1:0] due_cnt_reg, due_cnt_next;
    logic          jump_reg, jump_next;
    logic          final_any_reg, final_any_next;
    logic [4:0]    fire_tot_reg, fire_tot_next;
    logic [4:0]    fire_cnt_reg, fire_cnt_next;
    logic [63:0]   acc_reg, acc_next;

    logic        res_status_reg, res_status_next;
    logic        res_fired_reg, res_fired_next;
    logic [3:0]  res_id_reg, res_id_next;
    logic [63:0] res_left_reg, res_left_next;
    logic        res_front_reg, res_front_next;
    logic        res_jump_reg, res_jump_next;
    logic        res_final_reg, res_final_next;
    logic        res_last_reg, res_last_next;

    logic        m_valid_reg, m_valid_next;
    logic        m_status_reg, m_status_next;
    logic        m_fired_reg, m_fired_next;
    logic [3:0]  m_fired_id_reg, m_fired_id_next;
    logic [63:0] m_time_left_reg, m_time_left_next;
    logic        m_front_reg, m_front_next;
    logic        m_jump_reg, m_jump_next;
    logic        m_any_reg, m_any_next;
    logic        m_last_reg, m_last_next;

    // Slot stores
    logic [63:0] dl_mem [NUM_TIMERS];
    logic [31:0] per_mem [NUM_TIMERS];
    logic [63:0] dl_rd_reg;
    logic [31:0] per_rd_reg;
    logic        dl_we, per_we;
    logic [IW-1:0] wr_addr, rd_addr;
    logic [63:0] dl_wd;
    logic [31:0] per_wd;

    // Shared saturating adder
    logic [63:0] add_a;
    logic [31:0] add_b;
    logic [64:0] add_sum;
    logic [63:0] add_sat;

    logic [IW-1:0] slot;
    logic          id_ok, slot_armed, start_scan;
    logic [2:0]    op;

    assign slot       = IW'(id_reg);
    assign id_ok      = 32'(id_reg) < 32'(NUM_TIMERS);
    assign slot_armed = id_ok && armed_reg[slot];
    assign op         = query_reg ? dtt_pkg::CMD_NEXT : cmd_reg;

    assign add_sum = {1'b0, add_a} + {33'd0, add_b};
    assign add_sat = add_sum[64] ? dtt_pkg::ALL_ONES : add_sum[63:0];

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_fired        = m_fired_reg;
    assign m_fired_id     = m_fired_id_reg;
    assign m_time_left    = m_time_left_reg;
    assign m_front_notice = m_front_reg;
    assign m_clock_jumped = m_jump_reg;
    assign m_any_armed    = m_any_reg;
    assign m_last         = m_last_reg;

    // Memory ports
    always_ff @(posedge aclk) begin
        if (dl_we) begin
            dl_mem[wr_addr] <= dl_wd;
        end
        if (per_we) begin
            per_mem[wr_addr] <= per_wd;
        end
        dl_rd_reg  <= dl_mem[rd_addr];
        per_rd_reg <= per_mem[rd_addr];
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        ivl_next       = ivl_reg;
        rec_next       = rec_reg;
        fnow_next      = fnow_reg;
        now_next       = now_reg;
        query_next     = query_reg;
        armed_next     = armed_reg;
        rep_next       = rep_reg;
        due_next       = due_reg;
        notice_next    = notice_reg;
        prev_next      = prev_reg;
        scan_cnt_next  = scan_cnt_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        best_vld_next  = best_vld_reg;
        best_dl_next   = best_dl_reg;
        best_idx_next  = best_idx_reg;
        due_cnt_next   = due_cnt_reg;
        jump_next      = jump_reg;
        final_any_next = final_any_reg;
        fire_tot_next  = fire_tot_reg;
        fire_cnt_next  = fire_cnt_reg;
        acc_next       = acc_reg;
        res_status_next = res_status_reg;
        res_fired_next  = res_fired_reg;
        res_id_next     = res_id_reg;
        res_left_next   = res_left_reg;
        res_front_next  = res_front_reg;
        res_jump_next   = res_jump_reg;
        res_final_next  = res_final_reg;
        res_last_next   = res_last_reg;
        m_valid_next     = m_valid_reg;
        m_status_next    = m_status_reg;
        m_fired_next     = m_fired_reg;
        m_fired_id_next  = m_fired_id_reg;
        m_time_left_next = m_time_left_reg;
        m_front_next     = m_front_reg;
        m_jump_next      = m_jump_reg;
        m_any_next       = m_any_reg;
        m_last_next      = m_last_reg;
        dl_we   = 1'b0;
        per_we  = 1'b0;
        wr_addr = slot;
        rd_addr = slot;
        dl_wd   = add_sat;
        per_wd  = ivl_reg;
        add_a   = now_reg;
        add_b   = ivl_reg;
        start_scan = 1'b0;

        // Drop the output beat once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_cmd;
                    id_next    = s_timer_id;
                    ivl_next   = s_interval_ms;
                    rec_next   = s_recurring;
                    fnow_next  = s_restart_now;
                    now_next   = s_now_ms;
                    query_next = s_query_next;
                    state_next = S_START;
                end
            end

            S_START: begin
                // Default: one plain result beat
                res_status_next = dtt_pkg::STATUS_OK;
                res_fired_next  = 1'b0;
                res_id_next     = '0;
                res_left_next   = '0;
                res_front_next  = 1'b0;
                res_jump_next   = 1'b0;
                res_final_next  = 1'b0;
                res_last_next   = 1'b1;
                state_next      = S_EMIT;
                case (op)
                    dtt_pkg::CMD_NEXT: begin
                        notice_next = 1'b0;
                        mode_next   = SM_EARLY;
                        start_scan  = 1'b1;
                    end
                    dtt_pkg::CMD_ADD: begin
                        if (!id_ok || slot_armed) begin
                            res_status_next = dtt_pkg::STATUS_FAIL;
                        end else begin
                            dl_we = 1'b1;
                            per_we = 1'b1;
                            armed_next[slot] = 1'b1;
                            rep_next[slot] = rec_reg;
                            mode_next  = SM_EARLY;
                            start_scan = 1'b1;
                        end
                    end
                    dtt_pkg::CMD_CANCEL: begin
                        if (slot_armed) begin
                            armed_next[slot] = 1'b0;
                        end else begin
                            res_status_next = dtt_pkg::STATUS_FAIL;
                        end
                    end
                    dtt_pkg::CMD_REFRESH, dtt_pkg::CMD_RESET: begin
                        if (slot_armed) begin
                            state_next = S_SLOT;
                        end else begin
                            res_status_next = dtt_pkg::STATUS_FAIL;
                        end
                    end
                    dtt_pkg::CMD_EXPIRE: begin
                        if (|armed_reg) begin
                            jump_next = (prev_reg >= dtt_pkg::HOUR_MS) &&
                                        (now_reg < prev_reg - dtt_pkg::HOUR_MS);
                            prev_next    = now_reg;
                            due_next     = '0;
                            due_cnt_next = '0;
                            mode_next    = SM_DUE;
                            start_scan   = 1'b1;
                        end
                    end
                    default: begin
                        res_status_next = dtt_pkg::STATUS_FAIL;
                    end
                endcase
            end

            S_SLOT: begin
                state_next = S_EMIT;
                if (op == dtt_pkg::CMD_REFRESH) begin
                    add_b = per_rd_reg;
                    dl_we = 1'b1;
                end else if (ivl_reg != per_rd_reg || fnow_reg) begin
                    // Pick the restart point
                    if (fnow_reg) begin
                        acc_next = now_reg;
                    end else if (dl_rd_reg >= {32'd0, per_rd_reg}) begin
                        acc_next = dl_rd_reg - {32'd0, per_rd_reg};
                    end else begin
                        acc_next = '0;
                    end
                    state_next = S_RST2;
                end
            end

            S_RST2: begin
                add_a  = acc_reg;
                dl_we  = 1'b1;
                per_we = 1'b1;
                mode_next  = SM_EARLY;
                start_scan = 1'b1;
            end

            S_SCAN: begin
                // Issue one slot read per cycle
                rd_addr = scan_cnt_reg[IW-1:0];
                if (scan_cnt_reg != CW'(NUM_TIMERS)) begin
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_cnt_reg[IW-1:0];
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                // Compare the returning deadline
                if (cmp_vld_reg) begin
                    case (mode_reg)
                        SM_DUE: begin
                            if (armed_reg[cmp_idx_reg] &&
                                (jump_reg || dl_rd_reg <= now_reg)) begin
                                due_next[cmp_idx_reg] = 1'b1;
                                due_cnt_next = due_cnt_reg + 1'b1;
                            end
                        end
                        default: begin
                            if ((mode_reg == SM_PICK ? due_reg[cmp_idx_reg]
                                                     : armed_reg[cmp_idx_reg]) &&
                                (!best_vld_reg || dl_rd_reg < best_dl_reg)) begin
                                best_vld_next = 1'b1;
                                best_dl_next  = dl_rd_reg;
                                best_idx_next = cmp_idx_reg;
                            end
                        end
                    endcase
                    if (cmp_idx_reg == IW'(NUM_TIMERS - 1)) begin
                        state_next = S_AFTER;
                    end
                end
            end

            S_AFTER: begin
                state_next = S_EMIT;
                case (op)
                    dtt_pkg::CMD_NEXT: begin
                        if (!best_vld_reg) begin
                            res_left_next = dtt_pkg::ALL_ONES;
                        end else if (now_reg >= best_dl_reg) begin
                            res_left_next = '0;
                        end else begin
                            res_left_next = best_dl_reg - now_reg;
                        end
                    end
                    dtt_pkg::CMD_EXPIRE: begin
                        if (mode_reg == SM_PICK) begin
                            state_next = S_FIRE;
                        end else begin
                            final_any_next = (32'(due_cnt_reg) > dtt_pkg::MAX_RESULTS) ||
                                             (|(armed_reg & (rep_reg | ~due_reg)));
                            fire_tot_next = (32'(due_cnt_reg) > dtt_pkg::MAX_RESULTS)
                                            ? 5'(dtt_pkg::MAX_RESULTS) : 5'(due_cnt_reg);
                            fire_cnt_next = '0;
                            res_jump_next = jump_reg;
                            if (due_cnt_reg != '0) begin
                                state_next = S_SCAN;
                                mode_next  = SM_PICK;
                                start_scan = 1'b1;
                            end
                        end
                    end
                    default: begin
                        // Add or reset: flag a new front timer
                        if (best_vld_reg && best_idx_reg == slot && !notice_reg) begin
                            res_front_next = 1'b1;
                            notice_next    = 1'b1;
                        end
                    end
                endcase
            end

            S_FIRE: begin
                rd_addr    = best_idx_reg;
                state_next = S_FIRE2;
            end

            S_FIRE2: begin
                // Re-arm or disarm the picked timer
                wr_addr = best_idx_reg;
                add_b   = per_rd_reg;
                if (rep_reg[best_idx_reg]) begin
                    dl_we = 1'b1;
                end else begin
                    armed_next[best_idx_reg] = 1'b0;
                end
                due_next[best_idx_reg] = 1'b0;
                res_fired_next = 1'b1;
                res_id_next    = 4'(best_idx_reg);
                res_jump_next  = jump_reg;
                res_final_next = 1'b1;
                res_last_next  = (fire_cnt_reg + 1'b1 == fire_tot_reg);
                fire_cnt_next  = fire_cnt_reg + 1'b1;
                state_next     = S_EMIT;
            end

            S_EMIT: begin
                // Hand the beat to the output register
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_status_next    = res_status_reg;
                    m_fired_next     = res_fired_reg;
                    m_fired_id_next  = res_id_reg;
                    m_time_left_next = res_left_reg;
                    m_front_next     = res_front_reg;
                    m_jump_next      = res_jump_reg;
                    m_any_next       = res_final_reg ? final_any_reg : (|armed_reg);
                    m_last_next      = res_last_reg;
                    if (res_last_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        mode_next  = SM_PICK;
                        start_scan = 1'b1;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Open a fresh slot walk
        if (start_scan) begin
            state_next    = S_SCAN;
            scan_cnt_next = '0;
            cmp_vld_next  = 1'b0;
            best_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            mode_reg     <= SM_EARLY;
            armed_reg    <= '0;
            rep_reg      <= '0;
            due_reg      <= '0;
            notice_reg   <= 1'b0;
            prev_reg     <= '0;
            scan_cnt_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            best_vld_reg <= 1'b0;
            due_cnt_reg  <= '0;
            fire_tot_reg <= '0;
            fire_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            armed_reg    <= armed_next;
            rep_reg      <= rep_next;
            due_reg      <= due_next;
            notice_reg   <= notice_next;
            prev_reg     <= prev_next;
            scan_cnt_reg <= scan_cnt_next;
            cmp_vld_reg  <= cmp_vld_next;
            best_vld_reg <= best_vld_next;
            due_cnt_reg  <= due_cnt_next;
            fire_tot_reg <= fire_tot_next;
            fire_cnt_reg <= fire_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
        cmd_reg        <= cmd_next;
        id_reg         <= id_next;
        ivl_reg        <= ivl_next;
        rec_reg        <= rec_next;
        fnow_reg       <= fnow_next;
        now_reg        <= now_next;
        query_reg      <= query_next;
        cmp_idx_reg    <= cmp_idx_next;
        best_dl_reg    <= best_dl_next;
        best_idx_reg   <= best_idx_next;
        jump_reg       <= jump_next;
        final_any_reg  <= final_any_next;
        acc_reg        <= acc_next;
        res_status_reg <= res_status_next;
        res_fired_reg  <= res_fired_next;
        res_id_reg     <= res_id_next;
        res_left_reg   <= res_left_next;
        res_front_reg  <= res_front_next;
        res_jump_reg   <= res_jump_next;
        res_final_reg  <= res_final_next;
        res_last_reg   <= res_last_next;
        m_status_reg    <= m_status_next;
        m_fired_reg     <= m_fired_next;
        m_fired_id_reg  <= m_fired_id_next;
        m_time_left_reg <= m_time_left_next;
        m_front_reg     <= m_front_next;
        m_jump_reg      <= m_jump_next;
        m_any_reg       <= m_any_next;
        m_last_reg      <= m_last_next;
    end

endmodule

`default_nettype wire
